/* hdl/v3alu_pkg.sv */
// Shared types, codes and helpers for the three-component vector ALU.
// No dependencies; used by every module under hdl.
`default_nettype none

package v3alu_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;                // component width
	localparam int SW        = 49;                // scalar width
	localparam int QW        = FRAC_BITS + 1;     // normalise quotient width
	localparam int RT_STAGES = DW;                // one root bit per stage
	localparam int DV_STAGES = QW;                // one quotient bit per stage

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_SCALE = 4'd2,
		OP_DOT   = 4'd3,
		OP_CROSS = 4'd4,
		OP_MAGSQ = 4'd5,
		OP_MAG   = 4'd6,
		OP_NORM  = 4'd7,
		OP_EQ    = 4'd8
	} op_t;

	// how the back end finishes a word
	typedef enum logic [2:0] {
		CLS_EARLY,
		CLS_SCALE,
		CLS_DOT,
		CLS_CROSS,
		CLS_MAGSQ,
		CLS_MAG,
		CLS_NORM
	} cls_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	localparam logic signed [65:0] MAX32 = 66'sd2147483647;
	localparam logic signed [65:0] MIN32 = -MAX32 - 66'sd1;
	localparam logic signed [65:0] MAX49 = 66'sd281474976710655;
	localparam logic signed [65:0] MIN49 = -MAX49 - 66'sd1;

	typedef struct packed {
		cls_t             cls;
		logic [5:0][31:0] x;      // multiplier operands, lane k = x[k]*y[k]
		logic [5:0][31:0] y;
		logic [2:0][31:0] ev;     // add/sub result, ready at decode
		logic             esat;
		logic             eq;
		logic [2:0][31:0] a;      // A, kept for normalise
	} front_item_t;

	// {saturated, value}
	function automatic logic [32:0] sat32(input logic signed [65:0] v);
		logic [32:0] r;
		if (v > MAX32) begin
			r = {1'b1, 32'h7fff_ffff};
		end else if (v < MIN32) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/v3alu_front.sv */
// Front end: input register, operation decode and multiplier operand selection.
// Depends on v3alu_pkg.
`default_nettype none

module v3alu_front (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	input  wire  [223:0]               s_tdata,
	input  wire  [3:0]                 s_tuser,
	output logic                       out_valid,
	input  wire                        out_ready,
	output v3alu_pkg::front_item_t     out_item
);

	logic signed [31:0] ax, ay, az, bx, by, bz, sf;
	logic [32:0] sx, sy, sz;
	v3alu_pkg::front_item_t dec;
	v3alu_pkg::front_item_t item_q;
	logic valid_q;

	assign ax = s_tdata[31:0];
	assign ay = s_tdata[63:32];
	assign az = s_tdata[95:64];
	assign bx = s_tdata[127:96];
	assign by = s_tdata[159:128];
	assign bz = s_tdata[191:160];
	assign sf = s_tdata[223:192];

	always_comb begin
		sx = v3alu_pkg::sat32(66'(ax) + 66'(bx));
		sy = v3alu_pkg::sat32(66'(ay) + 66'(by));
		sz = v3alu_pkg::sat32(66'(az) + 66'(bz));
		dec      = '0;
		dec.cls  = v3alu_pkg::CLS_EARLY;
		dec.a    = {az, ay, ax};
		unique case (s_tuser) inside
			v3alu_pkg::OP_ADD: begin
				dec.ev   = {sz[31:0], sy[31:0], sx[31:0]};
				dec.esat = sx[32] | sy[32] | sz[32];
			end
			v3alu_pkg::OP_SUB: begin
				sx = v3alu_pkg::sat32(66'(ax) - 66'(bx));
				sy = v3alu_pkg::sat32(66'(ay) - 66'(by));
				sz = v3alu_pkg::sat32(66'(az) - 66'(bz));
				dec.ev   = {sz[31:0], sy[31:0], sx[31:0]};
				dec.esat = sx[32] | sy[32] | sz[32];
			end
			v3alu_pkg::OP_SCALE: begin
				dec.cls  = v3alu_pkg::CLS_SCALE;
				dec.x[0] = ax; dec.y[0] = sf;
				dec.x[2] = ay; dec.y[2] = sf;
				dec.x[4] = az; dec.y[4] = sf;
			end
			v3alu_pkg::OP_DOT: begin
				dec.cls  = v3alu_pkg::CLS_DOT;
				dec.x[0] = ax; dec.y[0] = bx;
				dec.x[2] = ay; dec.y[2] = by;
				dec.x[4] = az; dec.y[4] = bz;
			end
			v3alu_pkg::OP_CROSS: begin
				// lane pairs give ay*bz-az*by, az*bx-ax*bz, ax*by-ay*bx
				dec.cls  = v3alu_pkg::CLS_CROSS;
				dec.x[0] = ay; dec.y[0] = bz;
				dec.x[1] = az; dec.y[1] = by;
				dec.x[2] = az; dec.y[2] = bx;
				dec.x[3] = ax; dec.y[3] = bz;
				dec.x[4] = ax; dec.y[4] = by;
				dec.x[5] = ay; dec.y[5] = bx;
			end
			v3alu_pkg::OP_MAGSQ, v3alu_pkg::OP_MAG, v3alu_pkg::OP_NORM: begin
				if (s_tuser == v3alu_pkg::OP_MAGSQ) begin
					dec.cls = v3alu_pkg::CLS_MAGSQ;
				end else if (s_tuser == v3alu_pkg::OP_MAG) begin
					dec.cls = v3alu_pkg::CLS_MAG;
				end else begin
					dec.cls = v3alu_pkg::CLS_NORM;
				end
				dec.x[0] = ax; dec.y[0] = ax;
				dec.x[2] = ay; dec.y[2] = ay;
				dec.x[4] = az; dec.y[4] = az;
			end
			v3alu_pkg::OP_EQ: begin
				dec.eq = (ax == bx) && (ay == by) && (az == bz);
			end
			default: begin
				// unused codes: all-zero result
			end
		endcase
	end

	assign s_tready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_q <= dec;
		end
	end

endmodule

`default_nettype wire

/* hdl/v3alu_fifo.sv */
// Two-entry queue between front and back ends.
// Depends on v3alu_pkg.
`default_nettype none

module v3alu_fifo (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        wr_valid,
	output logic                       wr_ready,
	input  wire v3alu_pkg::front_item_t wr_item,
	output logic                       rd_valid,
	input  wire                        rd_ready,
	output v3alu_pkg::front_item_t     rd_item
);

	v3alu_pkg::front_item_t mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push, pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

/* hdl/v3alu_back.sv */
// Back end: multiplier stages, scalar finish, pipelined square root and
// pipelined normalise divide, then the output register. Depends on v3alu_pkg.
`default_nettype none

module v3alu_back (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire v3alu_pkg::front_item_t in_item,
	output logic                       m_tvalid,
	input  wire                        m_tready,
	output logic [151:0]               m_tdata
);

	localparam int F  = v3alu_pkg::FRAC_BITS;
	localparam int QW = v3alu_pkg::QW;
	localparam int RS = v3alu_pkg::RT_STAGES;
	localparam int DS = v3alu_pkg::DV_STAGES;

	typedef struct packed {
		v3alu_pkg::cls_t  cls;
		logic [2:0][31:0] ev;
		logic             esat;
		logic             eq;
		logic [2:0][31:0] a;
	} mid_t;

	typedef struct packed {
		v3alu_pkg::cls_t  cls;
		logic [2:0][31:0] r;
		logic [48:0]      scalar;
		logic             eq;
		logic [1:0]       status;
		logic [2:0]       neg;
		logic [2:0][31:0] mag;
	} res_t;

	typedef struct packed {
		logic [32:0] rem;
		logic [31:0] root;
		logic [63:0] n;
		res_t        res;
	} rt_t;

	typedef struct packed {
		logic [2:0][31:0]   rem;
		logic [2:0][QW-1:0] q;
		logic [31:0]        m;
		res_t               res;
	} dv_t;

	// one bit of the root per call
	function automatic rt_t sqrt_step(input rt_t e);
		rt_t         o;
		logic [34:0] rsh, trial;
		o     = e;
		rsh   = {e.rem, e.n[63:62]};
		trial = {1'b0, e.root, 2'b01};
		o.n   = {e.n[61:0], 2'b00};
		if (rsh >= trial) begin
			o.rem  = 33'(rsh - trial);
			o.root = {e.root[30:0], 1'b1};
		end else begin
			o.rem  = rsh[32:0];
			o.root = {e.root[30:0], 1'b0};
		end
		return o;
	endfunction

	// one quotient bit per lane per call
	function automatic dv_t div_step(input dv_t e, input logic [2:0] nb);
		dv_t         o;
		logic [32:0] rsh;
		o = e;
		for (int i = 0; i < 3; i++) begin
			rsh = {e.rem[i], nb[i]};
			if (rsh >= {1'b0, e.m}) begin
				o.rem[i] = 32'(rsh - {1'b0, e.m});
				o.q[i]   = {e.q[i][QW-2:0], 1'b1};
			end else begin
				o.rem[i] = rsh[31:0];
				o.q[i]   = {e.q[i][QW-2:0], 1'b0};
			end
		end
		return o;
	endfunction

	logic en;

	mid_t               mid_s1, mid_s2, mid_s3;
	logic signed [63:0] p_s1 [6];
	logic signed [64:0] t_s2 [3];
	logic signed [65:0] sum_s3;
	logic               v_s1, v_s2, v_s3;

	rt_t  rt_s [RS+1];
	logic rt_v [RS+1];
	dv_t  dv_s [DS];
	logic dv_v [DS];
	res_t out_q;
	logic out_v_q;

	// combinational stage results
	mid_t  mid3_d;
	rt_t   rt0_d;
	dv_t   dv0_d;
	res_t  fin_d;
	logic [32:0]        c0, c1, c2;
	logic signed [65:0] dsh;
	logic [63:0]        qsq;
	logic [31:0]        qx;

	assign en       = !out_v_q || m_tready;
	assign in_ready = en;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'b0, out_q.status, out_q.eq, out_q.scalar,
		out_q.r[2], out_q.r[1], out_q.r[0]};

	// stage 3: vector finish and the sum of the three lanes
	always_comb begin
		mid3_d = mid_s2;
		c0 = v3alu_pkg::sat32(66'(t_s2[0]) >>> F);
		c1 = v3alu_pkg::sat32(66'(t_s2[1]) >>> F);
		c2 = v3alu_pkg::sat32(66'(t_s2[2]) >>> F);
		if (mid_s2.cls == v3alu_pkg::CLS_SCALE || mid_s2.cls == v3alu_pkg::CLS_CROSS) begin
			mid3_d.ev   = {c2[31:0], c1[31:0], c0[31:0]};
			mid3_d.esat = c0[32] | c1[32] | c2[32];
		end
	end

	// stage 4: scalar finish, root set-up
	always_comb begin
		dsh = sum_s3 >>> F;
		qsq = sum_s3[63:0] >> F;
		rt0_d            = '0;
		rt0_d.n          = sum_s3[63:0];
		rt0_d.res.cls    = mid_s3.cls;
		rt0_d.res.eq     = mid_s3.eq;
		rt0_d.res.status = v3alu_pkg::ST_OK;
		for (int i = 0; i < 3; i++) begin
			rt0_d.res.neg[i] = mid_s3.a[i][31];
			rt0_d.res.mag[i] = mid_s3.a[i][31] ? (~mid_s3.a[i] + 32'd1) : mid_s3.a[i];
		end
		case (mid_s3.cls) inside
			v3alu_pkg::CLS_EARLY, v3alu_pkg::CLS_SCALE, v3alu_pkg::CLS_CROSS: begin
				rt0_d.res.r = mid_s3.ev;
				if (mid_s3.esat) rt0_d.res.status = v3alu_pkg::ST_SAT;
			end
			v3alu_pkg::CLS_DOT: begin
				if (dsh > v3alu_pkg::MAX49) begin
					rt0_d.res.scalar = v3alu_pkg::MAX49[48:0];
					rt0_d.res.status = v3alu_pkg::ST_SAT;
				end else if (dsh < v3alu_pkg::MIN49) begin
					rt0_d.res.scalar = v3alu_pkg::MIN49[48:0];
					rt0_d.res.status = v3alu_pkg::ST_SAT;
				end else begin
					rt0_d.res.scalar = dsh[48:0];
				end
			end
			v3alu_pkg::CLS_MAGSQ: begin
				if (qsq > 64'(v3alu_pkg::MAX49)) begin
					rt0_d.res.scalar = v3alu_pkg::MAX49[48:0];
					rt0_d.res.status = v3alu_pkg::ST_SAT;
				end else begin
					rt0_d.res.scalar = qsq[48:0];
				end
			end
			default: begin
				// magnitude and normalise finish after the root
			end
		endcase
	end

	// first divide step takes the low bit of |a|
	always_comb begin
		dv0_d     = '0;
		dv0_d.m   = rt_s[RS].root;
		dv0_d.res = rt_s[RS].res;
		for (int i = 0; i < 3; i++) begin
			dv0_d.rem[i] = {1'b0, rt_s[RS].res.mag[i][31:1]};
		end
		dv0_d = div_step(dv0_d, {rt_s[RS].res.mag[2][0], rt_s[RS].res.mag[1][0],
			rt_s[RS].res.mag[0][0]});
	end

	// final result selection
	always_comb begin
		fin_d = dv_s[DS-1].res;
		qx    = '0;
		if (fin_d.cls == v3alu_pkg::CLS_MAG) begin
			fin_d.scalar = 49'(dv_s[DS-1].m);
		end else if (fin_d.cls == v3alu_pkg::CLS_NORM) begin
			if (dv_s[DS-1].m == 32'd0) begin
				fin_d.r      = '0;
				fin_d.status = v3alu_pkg::ST_ZERO;
			end else begin
				for (int i = 0; i < 3; i++) begin
					qx         = 32'(dv_s[DS-1].q[i]);
					fin_d.r[i] = fin_d.neg[i] ? (~qx + 32'd1) : qx;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
			for (int k = 0; k <= RS; k++) rt_v[k] <= 1'b0;
			for (int k = 0; k < DS; k++)  dv_v[k] <= 1'b0;
		end else if (en) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			rt_v[0] <= v_s3;
			for (int k = 0; k < RS; k++) rt_v[k+1] <= rt_v[k];
			dv_v[0] <= rt_v[RS];
			for (int k = 0; k < DS-1; k++) dv_v[k+1] <= dv_v[k];
			out_v_q <= dv_v[DS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s1.cls  <= in_item.cls;
			mid_s1.ev   <= in_item.ev;
			mid_s1.esat <= in_item.esat;
			mid_s1.eq   <= in_item.eq;
			mid_s1.a    <= in_item.a;
			for (int k = 0; k < 6; k++) begin
				p_s1[k] <= $signed(in_item.x[k]) * $signed(in_item.y[k]);
			end
			mid_s2 <= mid_s1;
			for (int i = 0; i < 3; i++) begin
				t_s2[i] <= 65'(p_s1[2*i]) - 65'(p_s1[2*i+1]);
			end
			mid_s3 <= mid3_d;
			sum_s3 <= 66'(t_s2[0]) + 66'(t_s2[1]) + 66'(t_s2[2]);
			rt_s[0] <= rt0_d;
			for (int k = 0; k < RS; k++) rt_s[k+1] <= sqrt_step(rt_s[k]);
			dv_s[0] <= dv0_d;
			for (int k = 0; k < DS-1; k++) dv_s[k+1] <= div_step(dv_s[k], 3'b000);
			out_q <= fin_d;
		end
	end

endmodule

`default_nettype wire

/* hdl/vector3_alu.sv */
// Top level of the three-component vector ALU: front end, queue, back end.
// Depends on v3alu_pkg, v3alu_front, v3alu_fifo and v3alu_back.
//
//  channel   dir  signals                       word contents (low bit up)
//  --------  ---  ----------------------------  ---------------------------------------
//  s_ (in)   in   s_tvalid s_tready s_tdata      a_x a_y a_z b_x b_y b_z scale_factor
//                 s_tuser                        req_type
//  m_ (out)  out  m_tvalid m_tready m_tdata      r_x r_y r_z r_scalar is_equal status
//
// One word is taken per cycle and one result leaves per cycle in steady flow.
// After the accepting edge loads the front register, a word passes the queue, the
// multiply/sum stages, the root stages incl. set-up, the divide stages (one per
// quotient bit) and the output register; the root and divide stages make up most of it.
// arst_n clears all valid state; no clearing pass is needed.
// A stall on m_tready freezes the back end; the two-entry queue and front
// register then absorb words before s_tready falls.
`default_nettype none

module vector3_alu (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [223:0] s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, scale_factor
	input  wire  [3:0]   s_tuser,   // req_type
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [151:0] m_tdata    // r_x, r_y, r_z, r_scalar, is_equal, status, pad
);

	v3alu_pkg::front_item_t fr_item, q_item;
	logic fr_valid, fr_ready, q_valid, q_ready;

	// decode and operand selection
	v3alu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_item  (fr_item)
	);

	// decouples front from the stalled back end
	v3alu_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_item  (fr_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_item  (q_item)
	);

	// arithmetic pipeline and output register
	v3alu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.in_item  (q_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

/* tb/vector3_alu_checker.sv */
// Checker for vector3_alu: watches both stream channels, predicts each result word
// from the accepted input word and compares field by field. Depends on v3alu_pkg.
`timescale 1ns / 100ps

module vector3_alu_checker (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	input  wire          s_tready,
	input  wire  [223:0] s_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, scale_factor
	input  wire  [3:0]   s_tuser,   // req_type
	input  wire          m_tvalid,
	input  wire          m_tready,
	input  wire  [151:0] m_tdata,   // r_x, r_y, r_z, r_scalar, is_equal, status, pad
	output int           errors,
	output int           pending
);

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [48:0] sc;
		logic        eq;
		logic [1:0]  st;
	} alu_word_t;

	alu_word_t exp_results[$];

	function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic sat);
		if (v > 128'sd2147483647) begin
			sat = 1'b1;
			return 32'h7fff_ffff;
		end
		if (v < -128'sd2147483648) begin
			sat = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic [48:0] clamp49(input logic signed [127:0] v, inout logic sat);
		if (v > 128'sd281474976710655) begin
			sat = 1'b1;
			return {1'b0, {48{1'b1}}};
		end
		if (v < -128'sd281474976710656) begin
			sat = 1'b1;
			return {1'b1, 48'd0};
		end
		return v[48:0];
	endfunction

	// floor of the square root, one result bit per pass
	function automatic logic [63:0] root_floor(input logic [63:0] n_in);
		logic [63:0] n, res, bt;
		n   = n_in;
		res = 64'd0;
		bt  = 64'd1 << 62;
		while (bt > n)
			bt = bt >> 2;
		while (bt != 64'd0) begin
			if (n >= res + bt) begin
				n   = n - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic alu_word_t alu_predict(input logic [3:0] op, input logic [223:0] d);
		logic signed [127:0] a [3];
		logic signed [127:0] b [3];
		logic signed [127:0] s, v [3], t;
		logic [127:0] sq;
		logic [63:0]  m, mag, q;
		logic         vec, sat;
		alu_word_t    r;
		r   = '0;
		vec = 1'b0;
		sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			a[i] = $signed(d[32*i +: 32]);
			b[i] = $signed(d[32*(i+3) +: 32]);
			v[i] = '0;
		end
		s  = $signed(d[192 +: 32]);
		sq = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
		case (op)
			v3alu_pkg::OP_ADD: begin
				for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
				vec = 1'b1;
			end
			v3alu_pkg::OP_SUB: begin
				for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
				vec = 1'b1;
			end
			v3alu_pkg::OP_SCALE: begin
				for (int i = 0; i < 3; i++) v[i] = (a[i] * s) >>> v3alu_pkg::FRAC_BITS;
				vec = 1'b1;
			end
			v3alu_pkg::OP_DOT: begin
				t    = (a[0]*b[0] + a[1]*b[1] + a[2]*b[2]) >>> v3alu_pkg::FRAC_BITS;
				r.sc = clamp49(t, sat);
			end
			v3alu_pkg::OP_CROSS: begin
				v[0] = (a[1]*b[2] - a[2]*b[1]) >>> v3alu_pkg::FRAC_BITS;
				v[1] = (a[2]*b[0] - a[0]*b[2]) >>> v3alu_pkg::FRAC_BITS;
				v[2] = (a[0]*b[1] - a[1]*b[0]) >>> v3alu_pkg::FRAC_BITS;
				vec  = 1'b1;
			end
			v3alu_pkg::OP_MAGSQ: begin
				t    = $signed(sq >> v3alu_pkg::FRAC_BITS);
				r.sc = clamp49(t, sat);
			end
			v3alu_pkg::OP_MAG: begin
				r.sc = 49'(root_floor(sq[63:0]));
			end
			v3alu_pkg::OP_NORM: begin
				if (sq == 0) begin
					r.st = v3alu_pkg::ST_ZERO;
				end else begin
					m = root_floor(sq[63:0]);
					for (int i = 0; i < 3; i++) begin
						mag  = a[i] < 0 ? 64'(-a[i]) : 64'(a[i]);
						q    = (mag << v3alu_pkg::FRAC_BITS) / m;
						v[i] = a[i] < 0 ? -$signed({64'd0, q}) : $signed({64'd0, q});
					end
					vec = 1'b1;
				end
			end
			v3alu_pkg::OP_EQ: begin
				r.eq = (a[0] == b[0]) && (a[1] == b[1]) && (a[2] == b[2]);
			end
			default: ;
		endcase
		if (vec) begin
			r.x = clamp32(v[0], sat);
			r.y = clamp32(v[1], sat);
			r.z = clamp32(v[2], sat);
		end
		if (sat)
			r.st = v3alu_pkg::ST_SAT;
		return r;
	endfunction

	task automatic cmp_field(input string name, input logic [63:0] e, input logic [63:0] g);
		if (e !== g) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, e, g);
			errors++;
		end
	endtask

	initial begin
		errors  = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		alu_word_t e;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				exp_results.push_back(alu_predict(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				if (exp_results.size() == 0) begin
					$display("%0t: result word with nothing expected, got %h", $time, m_tdata);
					errors++;
				end else begin
					e = exp_results.pop_front();
					cmp_field("r_x", 64'(e.x), 64'(m_tdata[31:0]));
					cmp_field("r_y", 64'(e.y), 64'(m_tdata[63:32]));
					cmp_field("r_z", 64'(e.z), 64'(m_tdata[95:64]));
					cmp_field("r_scalar", 64'(e.sc), 64'(m_tdata[144:96]));
					cmp_field("is_equal", 64'(e.eq), 64'(m_tdata[145]));
					cmp_field("status", 64'(e.st), 64'(m_tdata[147:146]));
				end
			end
			pending <= exp_results.size();
		end
	end

endmodule

/* tb/tb_vector3_alu.sv */
// Testbench top for vector3_alu: clock, reset, bursty stimulus and a stalling sink.
// Depends on v3alu_pkg, vector3_alu and vector3_alu_checker.
`timescale 1ns / 100ps

module tb_vector3_alu;

	localparam int N_RANDOM  = 1400;
	localparam int CYC_LIMIT = 300000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [223:0] s_tdata = '0;
	logic [3:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [151:0] m_tdata;
	int           errors, pending;
	int           cycles = 0;

	always #5 clk = ~clk;

	vector3_alu dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	vector3_alu_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending)
	);

	// hard stop if the flow ever locks up
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("tb_vector3_alu: FAIL");
			$finish;
		end
	end

	// offer one word at the falling edge, hold it until accepted
	task automatic send_word(input logic [3:0] op, input logic [2:0][31:0] a,
			input logic [2:0][31:0] b, input logic [31:0] s);
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {s, b, a};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic idle_gap(input int n);
		@(negedge clk);
		s_tvalid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// components: mostly full random, some small, some at the edges of the range
	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000;
			1: case ($urandom_range(0, 4))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0;
				3: return 32'hffff_ffff;
				default: return 32'h0001_0000;
			endcase
			default: return $urandom;
		endcase
	endfunction

	// sink: its own stall pattern, with one long hold-off to back the pipe up
	initial begin
		int mode, len, n;
		bit held;
		held = 1'b0;
		n    = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			len  = $urandom_range(5, 60);
			if (!held && n > 500) begin
				held = 1'b1;
				@(negedge clk);
				m_tready = 1'b0;
				repeat (400) @(negedge clk);
				n += 400;
			end
			repeat (len) begin
				@(negedge clk);
				n++;
				case (mode)
					0: m_tready = 1'b1;
					1: m_tready = $urandom_range(0, 1);
					2: m_tready = ($urandom_range(0, 3) != 0);
					default: m_tready = n[0];
				endcase
			end
		end
	end

	initial begin
		logic [2:0][31:0] a, b;
		logic [31:0]      s;
		logic [3:0]       op;
		int               burst;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: range edges, every operation, saturation, zero normalise, unused codes
		a = {3{32'h7fff_ffff}};
		b = {3{32'h7fff_ffff}};
		send_word(v3alu_pkg::OP_ADD, a, b, 32'h0);
		send_word(v3alu_pkg::OP_SUB, {3{32'h8000_0000}}, b, 32'h0);
		send_word(v3alu_pkg::OP_ADD, {3{32'h8000_0000}}, {3{32'h8000_0000}}, 32'h0);
		send_word(v3alu_pkg::OP_SCALE, a, b, 32'h7fff_ffff);
		send_word(v3alu_pkg::OP_SCALE, {3{32'h8000_0000}}, b, 32'h8000_0000);
		send_word(v3alu_pkg::OP_SCALE, {3{32'hffff_ffff}}, b, 32'h0000_0001);
		send_word(v3alu_pkg::OP_DOT, {3{32'h8000_0000}}, {3{32'h8000_0000}}, 32'h0);
		send_word(v3alu_pkg::OP_DOT, a, {3{32'h8000_0000}}, 32'h0);
		send_word(v3alu_pkg::OP_CROSS, {32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000},
			{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}, 32'h0);
		send_word(v3alu_pkg::OP_CROSS, {32'h0, 32'h0, 32'h0001_0000},
			{32'h0, 32'h0001_0000, 32'h0}, 32'h0);
		send_word(v3alu_pkg::OP_MAGSQ, {3{32'h8000_0000}}, b, 32'h0);
		send_word(v3alu_pkg::OP_MAG, {3{32'h8000_0000}}, b, 32'h0);
		send_word(v3alu_pkg::OP_MAG, {32'h0, 32'h0, 32'h0000_0003}, b, 32'h0);
		send_word(v3alu_pkg::OP_NORM, '0, b, 32'h0);
		send_word(v3alu_pkg::OP_NORM, {3{32'h8000_0000}}, b, 32'h0);
		send_word(v3alu_pkg::OP_NORM, {32'h0, 32'hffff_fffd, 32'h0000_0004}, b, 32'h0);
		send_word(v3alu_pkg::OP_NORM, {32'h0, 32'h0, 32'h0000_0001}, b, 32'h0);
		send_word(v3alu_pkg::OP_EQ, a, a, 32'h0);
		send_word(v3alu_pkg::OP_EQ, a, {32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_fffe}, 32'h0);
		send_word(4'd9, a, b, 32'hffff_ffff);
		send_word(4'd15, a, b, 32'hffff_ffff);
		idle_gap(3);

		burst = $urandom_range(1, 30);
		for (int i = 0; i < N_RANDOM; i++) begin
			if ($urandom_range(0, 19) == 0)
				op = 4'($urandom_range(9, 15));
			else
				op = 4'($urandom_range(0, 8));
			for (int k = 0; k < 3; k++) begin
				a[k] = rand_comp();
				b[k] = rand_comp();
			end
			s = rand_comp();
			if (op == v3alu_pkg::OP_EQ && $urandom_range(0, 1))
				b = a;
			if (op == v3alu_pkg::OP_NORM && $urandom_range(0, 9) == 0)
				a = '0;
			send_word(op, a, b, s);
			// once mid-run, let the pipe drain completely
			if (i == N_RANDOM / 2) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				while (pending != 0)
					@(negedge clk);
			end
			if (--burst == 0) begin
				burst = $urandom_range(1, 30);
				if ($urandom_range(0, 3) != 0)
					idle_gap($urandom_range(1, 8));
			end
		end
		@(negedge clk);
		s_tvalid = 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("tb_vector3_alu: PASS");
		end else begin
			$display("tb_vector3_alu: FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/v3alu_pkg.sv
hdl/v3alu_front.sv
hdl/v3alu_fifo.sv
hdl/v3alu_back.sv
hdl/vector3_alu.sv
tb/vector3_alu_checker.sv
tb/tb_vector3_alu.sv
